FILE: hdl/ils_pkg.sv
// Shared types and constants for the indexed list store.
// No dependencies; used by ils_ctrl, ils_datapath and indexed_list_store.
`timescale 1ns / 1ps

package ils_pkg;

    localparam int DEPTH   = 16;
    localparam int MAX_OUT = 16;
    localparam int POS_W   = 8;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int OUT_W   = $clog2(MAX_OUT + 1);
    localparam int RN_W    = (CNT_W > OUT_W) ? CNT_W : OUT_W;

    typedef logic [CNT_W-1:0] ils_cnt_t;
    typedef logic [IDX_W-1:0] ils_idx_t;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_RM_FRONT  = 3'd3,
        OP_RM_BACK   = 3'd4,
        OP_RM_AT     = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_READ      = 3'd7
    } ils_op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } ils_status_t;

    typedef struct packed {
        ils_op_t            op;
        logic signed [31:0] value;
        logic [POS_W-1:0]   position;
    } ils_req_t;

    typedef struct packed {
        ils_status_t        status;
        logic signed [31:0] element;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               last;
    } ils_rsp_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_EXEC = 2'd1,
        CMD_READ = 2'd2
    } ils_cmd_kind_t;

    // controller -> datapath
    typedef struct packed {
        ils_cmd_kind_t kind;
        ils_idx_t      rd_idx;
        logic          rd_last;
    } ils_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic     count_zero;
        ils_idx_t final_idx;
    } ils_sts_t;

endpackage

FILE: hdl/ils_ctrl.sv
// Request sequencer for the indexed list store: accepts requests and steps
// read-outs one entry per cycle. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ils_pkg::ils_op_t  op,
    input  ils_pkg::ils_sts_t sts,
    output logic              busy,
    output ils_pkg::ils_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t            state_reg, state_next;
    ils_pkg::ils_idx_t idx_reg, idx_next;

    always_comb
    begin
        cmd         = '{kind: ils_pkg::CMD_NONE, rd_idx: '0, rd_last: 1'b0};
        state_next  = state_reg;
        idx_next    = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == ils_pkg::OP_READ && !sts.count_zero)
                    begin
                        // first entry goes out right away
                        cmd.kind    = ils_pkg::CMD_READ;
                        cmd.rd_idx  = '0;
                        cmd.rd_last = (sts.final_idx == '0);
                        if (!cmd.rd_last)
                        begin
                            state_next = S_READ;
                            idx_next   = ils_pkg::IDX_W'(1);
                        end
                    end
                    else
                    begin
                        cmd.kind = ils_pkg::CMD_EXEC;
                    end
                end
            end
            S_READ:
            begin
                cmd.kind    = ils_pkg::CMD_READ;
                cmd.rd_idx  = idx_reg;
                cmd.rd_last = (idx_reg == sts.final_idx);
                idx_next    = idx_reg + ils_pkg::IDX_W'(1);
                if (cmd.rd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy = (state_reg == S_READ);

endmodule

FILE: hdl/ils_datapath.sv
// Shifting entry row, entry count and result register of the indexed list
// store. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ils_pkg::ils_req_t req,
    input  ils_pkg::ils_cmd_t cmd,
    output ils_pkg::ils_sts_t sts,
    output logic              result_strobe,
    output ils_pkg::ils_rsp_t result
);

    logic signed [31:0]        entries_reg  [ils_pkg::DEPTH];
    logic signed [31:0]        entries_next [ils_pkg::DEPTH];
    ils_pkg::ils_cnt_t         count_reg, count_next;
    logic                      strobe_reg, strobe_next;
    ils_pkg::ils_rsp_t         rsp_reg, rsp_next;

    logic [ils_pkg::CMP_W-1:0] cnt_ext;
    logic [ils_pkg::CMP_W-1:0] tgt;
    logic [ils_pkg::RN_W-1:0]  read_n;
    logic                      is_ins, is_rm, do_ins, do_rm, full;
    ils_pkg::ils_status_t      status;
    logic signed [31:0]        rd_data;

    assign cnt_ext = ils_pkg::CMP_W'(count_reg);
    assign full    = (count_reg == ils_pkg::CNT_W'(ils_pkg::DEPTH));

    // decode the request against the current count
    always_comb
    begin
        tgt        = '0;
        is_ins     = 1'b0;
        is_rm      = 1'b0;
        do_ins     = 1'b0;
        do_rm      = 1'b0;
        status     = ils_pkg::ST_DONE;
        count_next = count_reg;
        case (req.op)
            ils_pkg::OP_INS_FRONT: is_ins = 1'b1;
            ils_pkg::OP_INS_BACK:
            begin
                is_ins = 1'b1;
                tgt    = cnt_ext;
            end
            ils_pkg::OP_INS_AT:
            begin
                is_ins = 1'b1;
                tgt    = ils_pkg::CMP_W'(req.position);
            end
            ils_pkg::OP_RM_FRONT: is_rm = 1'b1;
            ils_pkg::OP_RM_BACK:
            begin
                // wraps high on an empty list, which then reads as out of range
                is_rm = 1'b1;
                tgt   = cnt_ext - ils_pkg::CMP_W'(1);
            end
            ils_pkg::OP_RM_AT:
            begin
                is_rm = 1'b1;
                tgt   = ils_pkg::CMP_W'(req.position);
            end
            default: ;
        endcase

        if (is_ins)
        begin
            if (full)
                status = ils_pkg::ST_FULL;
            else if (tgt > cnt_ext)
                status = ils_pkg::ST_IGNORED;
            else
                do_ins = 1'b1;
        end
        if (is_rm)
        begin
            if (count_reg == '0 || tgt >= cnt_ext)
                status = ils_pkg::ST_IGNORED;
            else
                do_rm = 1'b1;
        end

        if (cmd.kind == ils_pkg::CMD_EXEC)
        begin
            if (do_ins)
                count_next = count_reg + ils_pkg::CNT_W'(1);
            else if (do_rm)
                count_next = count_reg - ils_pkg::CNT_W'(1);
            else if (req.op == ils_pkg::OP_CLEAR)
                count_next = '0;
        end
    end

    // each cell takes the new value, its left neighbor, its right neighbor, or holds
    always_comb
    begin
        for (int i = 0; i < ils_pkg::DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (cmd.kind == ils_pkg::CMD_EXEC && do_ins)
            begin
                if (ils_pkg::CMP_W'(i) == tgt)
                    entries_next[i] = req.value;
                else if (ils_pkg::CMP_W'(i) > tgt)
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
            end
            else if (cmd.kind == ils_pkg::CMD_EXEC && do_rm)
            begin
                if (ils_pkg::CMP_W'(i) >= tgt)
                    entries_next[i] = entries_reg[(i < ils_pkg::DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    assign rd_data = entries_reg[cmd.rd_idx];

    always_comb
    begin
        strobe_next = (cmd.kind != ils_pkg::CMD_NONE);
        if (cmd.kind == ils_pkg::CMD_READ)
        begin
            rsp_next.status      = ils_pkg::ST_DONE;
            rsp_next.element     = rd_data;
            rsp_next.entry_count = 5'(count_reg);
            rsp_next.is_empty    = 1'b0;
            rsp_next.last        = cmd.rd_last;
        end
        else
        begin
            rsp_next.status      = status;
            rsp_next.element     = '0;
            rsp_next.entry_count = 5'(count_next);
            rsp_next.is_empty    = (count_next == '0);
            rsp_next.last        = 1'b1;
        end
    end

    // read-out length is capped at MAX_OUT entries
    assign read_n = (ils_pkg::RN_W'(count_reg) > ils_pkg::RN_W'(ils_pkg::MAX_OUT))
                    ? ils_pkg::RN_W'(ils_pkg::MAX_OUT) : ils_pkg::RN_W'(count_reg);

    assign sts.count_zero = (count_reg == '0);
    assign sts.final_idx  = ils_pkg::IDX_W'(read_n - ils_pkg::RN_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
        rsp_reg     <= rsp_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = rsp_reg;

endmodule

FILE: hdl/indexed_list_store.sv
// Top level of the indexed list store: ties the request sequencer to the
// entry datapath. Depends on ils_pkg, ils_ctrl and ils_datapath.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. Insert,
// remove and clear requests each give a single result: it appears on
// result, with result_strobe high, in the cycle after the request is taken, and
// busy stays low, so a new request may follow every cycle. Inserts and removes
// shift the entry row by one place in that cycle. A read-out of n entries
// (n capped at 16) gives n results back to back, one entry a cycle through the
// entry select, with busy high while the entries after the first are issued;
// an empty list gives one result. Each result is shown for one cycle only and
// must be taken then: there is no way to hold it off.
module indexed_list_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ils_pkg::ils_req_t req,
    output logic              busy,
    output logic              result_strobe,
    output ils_pkg::ils_rsp_t result
);

    ils_pkg::ils_cmd_t cmd;
    ils_pkg::ils_sts_t sts;

    ils_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (req.op),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    ils_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .cmd           (cmd),
        .sts           (sts),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // a non-read request answers with one final result in the next cycle
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.op != ils_pkg::OP_READ |=> result_strobe && result.last)
        else $error("single result missing after request");

    // a read-out streams without gaps until its last entry
    a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |=> result_strobe)
        else $error("read-out stream broke before last entry");

    // busy only follows a read-out that still has entries to send
    a_busy_stream: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> result_strobe && !result.last)
        else $error("busy without a read-out in progress");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.is_empty |-> result.entry_count == 5'd0)
        else $error("empty list reported with nonzero count");

endmodule
